/* rtl/bed_pkg.sv */
`default_nettype none

package bed_pkg;

	typedef logic [2:0] kind_t;

	localparam kind_t EV_RELEASED = 3'd0;
	localparam kind_t EV_PRESSED  = 3'd1;
	localparam kind_t EV_DOUBLE   = 3'd2;
	localparam kind_t EV_SHORT    = 3'd3;
	localparam kind_t EV_LONG     = 3'd4;
	localparam kind_t EV_LONGEST  = 3'd5;

	localparam int OPT_PRESS    = 0;
	localparam int OPT_RELEASE  = 1;
	localparam int OPT_DOUBLE   = 2;
	localparam int OPT_SHORT    = 3;
	localparam int OPT_LONG     = 4;
	localparam int OPT_LONGEST  = 5;
	localparam int OPT_REPEAT   = 6;
	localparam int OPT_IDLE_LOW = 7;

	localparam logic [2:0] REG_TICK     = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE = 3'd1;
	localparam logic [2:0] REG_HOLDOFF  = 3'd2;
	localparam logic [2:0] REG_DOUBLE   = 3'd3;
	localparam logic [2:0] REG_LONG     = 3'd4;
	localparam logic [2:0] REG_LONGEST  = 3'd5;
	localparam logic [2:0] REG_REPEAT   = 3'd6;
	localparam logic [2:0] REG_OPTIONS  = 3'd7;

	localparam logic [7:0]  RST_TICK     = 8'd5;
	localparam logic [7:0]  RST_DEBOUNCE = 8'd2;
	localparam logic [15:0] RST_HOLDOFF  = 16'd50;
	localparam logic [15:0] RST_DOUBLE   = 16'd300;
	localparam logic [15:0] RST_LONG     = 16'd1000;
	localparam logic [15:0] RST_LONGEST  = 16'd3000;
	localparam logic [15:0] RST_REPEAT   = 16'd200;
	localparam logic [7:0]  RST_OPTIONS  = 8'd3;
	localparam logic        RST_LEVEL    = 1'b1;
	localparam logic [31:0] RST_TIME     = 32'd1000;
	localparam logic [8:0]  RST_SETTLE   = 9'd3;

	typedef struct packed {
		logic [7:0]  tick_ms;
		logic [7:0]  debounce_count;
		logic [15:0] holdoff_ms;
		logic [15:0] double_ms;
		logic [15:0] long_ms;
		logic [15:0] longest_ms;
		logic [15:0] repeat_ms;
		logic [7:0]  options;
	} cfg_t;

	typedef struct packed {
		logic        sample_level;
		logic        stable_level;
		logic [31:0] check_time;
		logic [31:0] press_time;
		logic [31:0] change_time;
		logic [8:0]  settle_count;
		logic        double_seen;
		logic        repeat_on;
	} state_t;

	typedef struct packed {
		logic [1:0]       count;
		logic [2:0][2:0]  kind;
	} group_t;

endpackage

`default_nettype wire

/* rtl/bed_eval.sv */
`default_nettype none

module bed_eval (
	input  var bed_pkg::cfg_t   cfg,
	input  var bed_pkg::state_t st,
	input  wire  [31:0]         now_ms,
	input  wire                 pin_level,
	output bed_pkg::state_t     nx,
	output bed_pkg::group_t     group
);

	logic                  idle;
	logic                  mismatch;
	logic [31:0]           dt_tick;
	logic [31:0]           since_change;
	logic [31:0]           held;
	logic [1:0]            nb;
	logic [3:0]            cand_en;
	bed_pkg::kind_t [3:0]  cand_kind;
	logic [1:0]            cnt;

	assign idle         = ~cfg.options[bed_pkg::OPT_IDLE_LOW];
	assign dt_tick      = now_ms - st.check_time;
	assign since_change = now_ms - st.change_time;
	assign held         = now_ms - st.press_time;

	always_comb begin
		nx        = st;
		mismatch  = 1'b0;
		nb        = 2'd0;
		cand_en   = '0;
		cand_kind = '0;
		if (dt_tick > {24'd0, cfg.tick_ms}) begin
			nx.check_time = now_ms;
			if (st.sample_level != pin_level) begin
				mismatch        = 1'b1;
				nx.sample_level = pin_level;
				if (pin_level != idle) begin
					nx.press_time = now_ms;
				end
			end else if (st.settle_count < {1'b0, cfg.debounce_count}) begin
				nb = 2'd1;
			end else if (st.settle_count == {1'b0, cfg.debounce_count}) begin
				if (since_change > {16'd0, cfg.holdoff_ms} &&
				    st.sample_level != st.stable_level) begin
					if (st.sample_level == idle) begin
						cand_en[0]   = cfg.options[bed_pkg::OPT_RELEASE];
						cand_kind[0] = bed_pkg::EV_RELEASED;
						nx.repeat_on = 1'b0;
					end else begin
						cand_en[0]   = cfg.options[bed_pkg::OPT_PRESS];
						cand_kind[0] = bed_pkg::EV_PRESSED;
						if (cfg.options[bed_pkg::OPT_DOUBLE] &&
						    since_change < {16'd0, cfg.double_ms}) begin
							cand_en[1]     = 1'b1;
							cand_kind[1]   = bed_pkg::EV_DOUBLE;
							nx.double_seen = 1'b1;
							nb             = nb + 2'd1;
						end
					end
					nx.stable_level = st.sample_level;
					nx.change_time  = now_ms;
				end
				if (st.sample_level == idle && held < {16'd0, cfg.longest_ms}) begin
					if (cfg.options[bed_pkg::OPT_DOUBLE]) begin
						if (held > {16'd0, cfg.double_ms}) begin
							if (!st.double_seen && cfg.options[bed_pkg::OPT_SHORT] &&
							    held < {16'd0, cfg.long_ms}) begin
								cand_en[2]   = 1'b1;
								cand_kind[2] = bed_pkg::EV_SHORT;
							end
							nb             = nb + 2'd1;
							nx.double_seen = 1'b0;
						end
					end else if (cfg.options[bed_pkg::OPT_SHORT] &&
					             held < {16'd0, cfg.long_ms}) begin
						cand_en[2]   = 1'b1;
						cand_kind[2] = bed_pkg::EV_SHORT;
						nb           = nb + 2'd1;
					end
					if (cfg.options[bed_pkg::OPT_LONG] && held > {16'd0, cfg.long_ms}) begin
						cand_en[3]   = 1'b1;
						cand_kind[3] = bed_pkg::EV_LONG;
						nb           = nb + 2'd1;
					end
				end else if (st.sample_level != idle) begin
					if (held > {16'd0, cfg.longest_ms}) begin
						cand_en[2]   = cfg.options[bed_pkg::OPT_LONGEST];
						cand_kind[2] = bed_pkg::EV_LONGEST;
						if (cfg.options[bed_pkg::OPT_REPEAT]) begin
							nx.repeat_on = 1'b1;
						end
						nb = nb + 2'd1;
					end else if (held > {16'd0, cfg.long_ms}) begin
						if (cfg.options[bed_pkg::OPT_REPEAT]) begin
							cand_en[2]   = 1'b1;
							cand_kind[2] = bed_pkg::EV_SHORT;
							nx.repeat_on = 1'b1;
							nb           = nb + 2'd1;
						end
					end
				end
			end else if (st.sample_level != idle && st.repeat_on) begin
				if (held > {16'd0, cfg.repeat_ms}) begin
					cand_en[0]    = 1'b1;
					cand_kind[0]  = bed_pkg::EV_SHORT;
					nx.press_time = now_ms;
				end
			end
		end
		if (mismatch) begin
			nx.settle_count = '0;
		end else begin
			nx.settle_count = st.settle_count + {7'd0, nb};
		end
	end

	// Events are packed in order into the three result slots.
	always_comb begin
		group = '0;
		cnt   = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand_en[i] && cnt != 2'd3) begin
				group.kind[cnt] = cand_kind[i];
				cnt             = cnt + 2'd1;
			end
		end
		group.count = cnt;
	end

endmodule

`default_nettype wire

/* rtl/bed_group_fifo.sv */
`default_nettype none

module bed_group_fifo #(
	parameter int DEPTH = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  var bed_pkg::group_t push_data,
	input  wire             pop,
	output bed_pkg::group_t head,
	output logic            full,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bed_pkg::group_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/button_event_detector_core.sv */
// Debounce and event detection for one push button.
// Input channel: in_valid/in_stall with now_ms (free-running ms time) and
// pin_level. A request is taken at a clock edge with in_valid high and
// in_stall low. Each request is evaluated in the cycle it is accepted by one
// pass of compare and subtract logic, so a new request can enter every cycle
// while in_stall is low. Output channel: out_valid/out_stall with event_kind
// and last_of_run. The events of one request (up to three) leave one per
// cycle while out_stall is low, once their group reaches the queue head,
// with last_of_run on the final one. A request with no event outputs nothing.
// A small queue of GROUP_DEPTH event groups separates the sides; in_stall is
// high only while that queue is full, which happens when the receiver stalls
// or a request with several events is still draining.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at the
// next edge and should be done while no events are pending.
// Reset clears the queue, loads the default registers, sets the button state
// to the idle level, check and press times to 1000 ms, change time to 0.
`default_nettype none

module button_event_detector_core #(
	parameter int GROUP_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [31:0] now_ms,
	input  wire         pin_level,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  event_kind,
	output logic        last_of_run
);

	bed_pkg::cfg_t   cfg_q;
	bed_pkg::state_t state_q;
	bed_pkg::state_t state_nx;
	bed_pkg::group_t group;
	bed_pkg::group_t head;
	logic            full;
	logic            empty;
	logic            in_fire;
	logic            out_fire;
	logic            head_last;
	logic [1:0]      sub_q;

	bed_eval u_eval (
		.cfg       (cfg_q),
		.st        (state_q),
		.now_ms    (now_ms),
		.pin_level (pin_level),
		.nx        (state_nx),
		.group     (group)
	);

	bed_group_fifo #(
		.DEPTH (GROUP_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire && group.count != 2'd0),
		.push_data (group),
		.pop       (out_fire && head_last),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	assign in_stall    = full;
	assign in_fire     = in_valid && !in_stall;
	assign out_valid   = !empty;
	assign out_fire    = out_valid && !out_stall;
	assign head_last   = (sub_q == head.count - 2'd1);
	assign event_kind  = head.kind[sub_q];
	assign last_of_run = head_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms        <= bed_pkg::RST_TICK;
			cfg_q.debounce_count <= bed_pkg::RST_DEBOUNCE;
			cfg_q.holdoff_ms     <= bed_pkg::RST_HOLDOFF;
			cfg_q.double_ms      <= bed_pkg::RST_DOUBLE;
			cfg_q.long_ms        <= bed_pkg::RST_LONG;
			cfg_q.longest_ms     <= bed_pkg::RST_LONGEST;
			cfg_q.repeat_ms      <= bed_pkg::RST_REPEAT;
			cfg_q.options        <= bed_pkg::RST_OPTIONS;
		end else if (cfg_we) begin
			case (cfg_index)
				bed_pkg::REG_TICK:     cfg_q.tick_ms        <= cfg_data[7:0];
				bed_pkg::REG_DEBOUNCE: cfg_q.debounce_count <= cfg_data[7:0];
				bed_pkg::REG_HOLDOFF:  cfg_q.holdoff_ms     <= cfg_data;
				bed_pkg::REG_DOUBLE:   cfg_q.double_ms      <= cfg_data;
				bed_pkg::REG_LONG:     cfg_q.long_ms        <= cfg_data;
				bed_pkg::REG_LONGEST:  cfg_q.longest_ms     <= cfg_data;
				bed_pkg::REG_REPEAT:   cfg_q.repeat_ms      <= cfg_data;
				bed_pkg::REG_OPTIONS:  cfg_q.options        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.sample_level <= bed_pkg::RST_LEVEL;
			state_q.stable_level <= bed_pkg::RST_LEVEL;
			state_q.check_time   <= bed_pkg::RST_TIME;
			state_q.press_time   <= bed_pkg::RST_TIME;
			state_q.change_time  <= '0;
			state_q.settle_count <= bed_pkg::RST_SETTLE;
			state_q.double_seen  <= 1'b0;
			state_q.repeat_on    <= 1'b0;
		end else if (in_fire) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (out_fire) begin
			sub_q <= head_last ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

/* rtl/bed_checker.sv */
`default_nettype none

module bed_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire  [2:0] event_kind,
	input wire        last_of_run
);

	// A stalled event holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(last_of_run))
		else $error("stalled event changed");

	// Events appear only after a request has been accepted.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("event without an accepted request");

	// Only defined event codes are shown.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind <= bed_pkg::EV_LONGEST)
		else $error("undefined event code");

	// A run that is not finished continues in the next cycle.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("event run broken off");

endmodule

bind button_event_detector_core bed_checker u_bed_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.event_kind  (event_kind),
	.last_of_run (last_of_run)
);

`default_nettype wire

/* dv/button_event_detector_core_tb.sv */
`timescale 1ns / 1ps

module button_event_detector_core_tb;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		bed_pkg::kind_t kind;
		logic           last;
	} button_event_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] now_ms;
	logic        pin_level;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_kind;
	logic        last_of_run;

	bed_pkg::cfg_t   cfg;
	bed_pkg::state_t st;
	bed_pkg::kind_t  staged_kinds[$];
	button_event_t   events_due[$];
	button_event_t   want;

	int          fail_count = 0;
	int          results_seen = 0;
	int          gesture_items = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic [31:0] ms_now = 32'd0;
	logic        pin_now = 1'b1;

	button_event_detector_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms(now_ms),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic bed_pkg::cfg_t setup_of(input logic [7:0] tick, input logic [7:0] deb,
			input logic [15:0] hold, input logic [15:0] dbl, input logic [15:0] lng,
			input logic [15:0] lngst, input logic [15:0] rep, input logic [7:0] opt);
		bed_pkg::cfg_t s;
		s.tick_ms = tick;
		s.debounce_count = deb;
		s.holdoff_ms = hold;
		s.double_ms = dbl;
		s.long_ms = lng;
		s.longest_ms = lngst;
		s.repeat_ms = rep;
		s.options = opt;
		return s;
	endfunction

	function automatic bed_pkg::cfg_t random_setup();
		bed_pkg::cfg_t s;
		s.tick_ms = 8'($urandom_range(0, 15));
		s.debounce_count = 8'($urandom_range(0, 3));
		s.holdoff_ms = 16'($urandom_range(0, 120));
		s.double_ms = 16'($urandom_range(50, 500));
		s.long_ms = 16'($urandom_range(150, 1200));
		s.longest_ms = s.long_ms + 16'($urandom_range(0, 2500));
		s.repeat_ms = 16'($urandom_range(10, 400));
		s.options = 8'($urandom_range(0, 255));
		return s;
	endfunction

	function automatic void reset_model();
		cfg = setup_of(bed_pkg::RST_TICK, bed_pkg::RST_DEBOUNCE, bed_pkg::RST_HOLDOFF,
			bed_pkg::RST_DOUBLE, bed_pkg::RST_LONG, bed_pkg::RST_LONGEST,
			bed_pkg::RST_REPEAT, bed_pkg::RST_OPTIONS);
		st.sample_level = bed_pkg::RST_LEVEL;
		st.stable_level = bed_pkg::RST_LEVEL;
		st.check_time = bed_pkg::RST_TIME;
		st.press_time = bed_pkg::RST_TIME;
		st.change_time = 32'd0;
		st.settle_count = bed_pkg::RST_SETTLE;
		st.double_seen = 1'b0;
		st.repeat_on = 1'b0;
	endfunction

	function automatic void note_event(input bed_pkg::kind_t k);
		if (staged_kinds.size() < 3)
			staged_kinds.push_back(k);
	endfunction

	function automatic void predict_events(input logic [31:0] t, input logic lvl);
		logic          idle;
		logic [31:0]   gap;
		logic [31:0]   since;
		logic [31:0]   held;
		button_event_t ev;
		idle = ~cfg.options[bed_pkg::OPT_IDLE_LOW];
		staged_kinds.delete();
		gap = t - st.check_time;
		if (gap > cfg.tick_ms) begin
			st.check_time = t;
			if (st.sample_level != lvl) begin
				st.settle_count = 9'd0;
				st.sample_level = lvl;
				if (lvl != idle)
					st.press_time = t;
			end else if (st.settle_count < cfg.debounce_count) begin
				st.settle_count = st.settle_count + 9'd1;
			end else if (st.settle_count == cfg.debounce_count) begin
				since = t - st.change_time;
				if (since > cfg.holdoff_ms && st.sample_level != st.stable_level) begin
					if (st.sample_level == idle) begin
						if (cfg.options[bed_pkg::OPT_RELEASE])
							note_event(bed_pkg::EV_RELEASED);
						st.repeat_on = 1'b0;
					end else begin
						if (cfg.options[bed_pkg::OPT_PRESS])
							note_event(bed_pkg::EV_PRESSED);
						if (cfg.options[bed_pkg::OPT_DOUBLE] && since < cfg.double_ms) begin
							note_event(bed_pkg::EV_DOUBLE);
							st.double_seen = 1'b1;
							st.settle_count = st.settle_count + 9'd1;
						end
					end
					st.stable_level = st.sample_level;
					st.change_time = t;
				end
				held = t - st.press_time;
				if (st.sample_level == idle && held < cfg.longest_ms) begin
					if (cfg.options[bed_pkg::OPT_DOUBLE]) begin
						if (held > cfg.double_ms) begin
							if (!st.double_seen && cfg.options[bed_pkg::OPT_SHORT] &&
									held < cfg.long_ms)
								note_event(bed_pkg::EV_SHORT);
							st.settle_count = st.settle_count + 9'd1;
							st.double_seen = 1'b0;
						end
					end else if (cfg.options[bed_pkg::OPT_SHORT] && held < cfg.long_ms) begin
						note_event(bed_pkg::EV_SHORT);
						st.settle_count = st.settle_count + 9'd1;
					end
					if (cfg.options[bed_pkg::OPT_LONG] && held > cfg.long_ms) begin
						note_event(bed_pkg::EV_LONG);
						st.settle_count = st.settle_count + 9'd1;
					end
				end else if (st.sample_level != idle) begin
					if (held > cfg.longest_ms) begin
						if (cfg.options[bed_pkg::OPT_LONGEST])
							note_event(bed_pkg::EV_LONGEST);
						if (cfg.options[bed_pkg::OPT_REPEAT])
							st.repeat_on = 1'b1;
						st.settle_count = st.settle_count + 9'd1;
					end else if (held > cfg.long_ms) begin
						if (cfg.options[bed_pkg::OPT_REPEAT]) begin
							note_event(bed_pkg::EV_SHORT);
							st.repeat_on = 1'b1;
							st.settle_count = st.settle_count + 9'd1;
						end
					end
				end
			end else if (st.sample_level != idle && st.repeat_on) begin
				held = t - st.press_time;
				if (held > cfg.repeat_ms) begin
					note_event(bed_pkg::EV_SHORT);
					st.press_time = t;
				end
			end
		end
		foreach (staged_kinds[i]) begin
			ev.kind = staged_kinds[i];
			ev.last = (i == staged_kinds.size() - 1);
			events_due.push_back(ev);
		end
	endfunction

	function automatic void report_mismatch(input string field, input logic [2:0] exp_v,
			input logic [2:0] got_v);
		if (fail_count < 40)
			$display("%0t: %s expected %0d, got %0d", $time, field, exp_v, got_v);
		fail_count++;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (events_due.size() == 0) begin
					if (fail_count < 40)
						$display("%0t: expected no result, got event_kind %0d last_of_run %0b",
							$time, event_kind, last_of_run);
					fail_count++;
				end else begin
					want = events_due.pop_front();
					if (event_kind !== want.kind)
						report_mismatch("event_kind", want.kind, event_kind);
					if (last_of_run !== want.last)
						report_mismatch("last_of_run", {2'b00, want.last}, {2'b00, last_of_run});
				end
			end
			if (in_valid && !in_stall)
				predict_events(now_ms, pin_level);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [31:0] t, input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		pin_level <= lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_quiet(input int pause);
		in_valid <= 1'b0;
		while (events_due.size() != 0)
			@(negedge clk);
		repeat (pause) @(negedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	// The upper byte of an 8-bit register write carries junk that must be ignored.
	task automatic load_setup(input bed_pkg::cfg_t s);
		logic [7:0] junk;
		wait_quiet(6);
		junk = 8'($urandom);
		put_reg(bed_pkg::REG_TICK, {junk, s.tick_ms});
		put_reg(bed_pkg::REG_DEBOUNCE, {~junk, s.debounce_count});
		put_reg(bed_pkg::REG_HOLDOFF, s.holdoff_ms);
		put_reg(bed_pkg::REG_DOUBLE, s.double_ms);
		put_reg(bed_pkg::REG_LONG, s.long_ms);
		put_reg(bed_pkg::REG_LONGEST, s.longest_ms);
		put_reg(bed_pkg::REG_REPEAT, s.repeat_ms);
		put_reg(bed_pkg::REG_OPTIONS, {junk, s.options});
		cfg_we <= 1'b0;
		cfg = s;
	endtask

	task automatic drive_level(input logic lvl, input int n, input int step_ms,
			input int jitter_ms);
		repeat (n) begin
			ms_now = ms_now + step_ms + $urandom_range(0, jitter_ms);
			send_request(ms_now, lvl);
		end
		pin_now = lvl;
	endtask

	task automatic random_gesture();
		int roll;
		int n;
		int span;
		roll = $urandom_range(99);
		if (roll < 8) begin
			if (roll < 3)
				ms_now = $urandom;
			else
				ms_now = ms_now + $urandom_range(0, int'(cfg.tick_ms));
			send_request(ms_now, 1'($urandom_range(1)));
			gesture_items += 1;
		end else begin
			n = $urandom_range(1, int'(cfg.debounce_count) + 3);
			case ($urandom_range(2))
				0: span = 20;
				1: span = 250;
				default: span = 900;
			endcase
			drive_level((roll < 88) ? ~pin_now : pin_now, n, int'(cfg.tick_ms) + 1, span);
			gesture_items += n;
		end
	endtask

	task automatic test_reset_defaults();
		send_idle_pct = 0;
		stall_pct = 0;
		ms_now = 32'd1003;
		send_request(ms_now, 1'b1);
		drive_level(1'b0, 4, 10, 0);
		drive_level(1'b1, 4, 10, 0);
	endtask

	task automatic test_register_extremes();
		load_setup(setup_of(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'hFF));
		send_request(32'hFFFF_FFFF, 1'b1);
		send_request(32'h0000_0000, 1'b0);
		ms_now = 32'h0000_0200;
		send_request(ms_now, 1'b1);
		pin_now = 1'b1;
	endtask

	task automatic test_every_event();
		load_setup(setup_of(8'd0, 8'd0, 16'd0, 16'd100, 16'd300, 16'd600, 16'd50, 8'h7F));
		drive_level(1'b0, 2, 10, 0);
		drive_level(1'b1, 2, 10, 0);
		drive_level(1'b0, 2, 10, 0);
		drive_level(1'b1, 2, 200, 0);
		drive_level(1'b0, 2, 10, 0);
		drive_level(1'b0, 3, 250, 0);
		drive_level(1'b1, 2, 10, 0);
	endtask

	task automatic test_random_gestures(input int n_items, input int send_pct,
			input int stall_percent);
		int first_item;
		int first_result;
		send_idle_pct = send_pct;
		stall_pct = stall_percent;
		load_setup(random_setup());
		first_item = gesture_items;
		first_result = results_seen;
		while (gesture_items - first_item < n_items ||
				(results_seen - first_result < 12 && gesture_items - first_item < 3 * n_items))
			random_gesture();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bed_pkg::REG_TICK;
		cfg_data = 16'd0;
		in_valid = 1'b0;
		now_ms = 32'd0;
		pin_level = 1'b1;
		reset_model();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_every_event();
		test_random_gestures(48, 0, 0);
		test_random_gestures(48, 0, 0);
		test_random_gestures(48, 63, 0);
		test_random_gestures(48, 63, 0);
		test_random_gestures(48, 0, 63);
		test_random_gestures(48, 0, 63);
		test_random_gestures(48, 24, 24);
		test_random_gestures(48, 24, 24);
		wait_quiet(20);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* button_event_detector_core.f */
rtl/bed_pkg.sv
rtl/bed_eval.sv
rtl/bed_group_fifo.sv
rtl/button_event_detector_core.sv
rtl/bed_checker.sv
dv/button_event_detector_core_tb.sv
